### rtl/sstt_pkg.sv
// ----------------------------------------------------------------------------
// sstt_pkg
// Shared types and constants of the subresource state transition tracker:
// register indexes, error codes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package sstt_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_SUB_COUNT = 2'd0;
	localparam logic [1:0] REG_LOCKED    = 2'd1;
	localparam logic [1:0] REG_INIT      = 2'd2;

	// Result error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_LOCKED = 2'd1;
	localparam logic [1:0] ERR_RANGE  = 2'd2;

	// Largest number of tracked subresources a result list can cover
	localparam int unsigned RESULT_LIMIT = 64;

	// Table address source
	typedef enum logic [1:0] {
		ADDR_IDX,
		ADDR_PTR,
		ADDR_RD
	} addr_sel_t;

	// Kind of result loaded into the output register
	typedef enum logic [1:0] {
		OUT_ERR,
		OUT_SINGLE,
		OUT_ALL,
		OUT_PEND
	} out_kind_t;

	// Controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_ERR,
		S_SGL,
		S_FIRST,
		S_SCAN,
		S_ALL,
		S_FILL,
		S_DRD,
		S_DIFF,
		S_FLUSH
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic      req_load;
		logic      rd_en;
		addr_sel_t rd_sel;
		logic      wr_en;
		addr_sel_t wr_sel;
		logic      ptr_clr;
		logic      ptr_inc;
		logic      first_load;
		logic      pend_load;
		logic      out_load;
		out_kind_t out_kind;
		logic      out_last;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic locked;
		logic whole;
		logic oob;
		logic one_entry;
		logic rd_eq_ns;
		logic rd_eq_first;
		logic first_eq_ns;
		logic rd_at_end;
		logic ptr_at_end;
		logic pend_valid;
		logic out_free;
	} status_t;

endpackage

### rtl/sstt_ctrl.sv
// ----------------------------------------------------------------------------
// sstt_ctrl
// Controller of the tracker: sequences the checks, the equality scan, the
// per-entry update pass and the table fill, and issues datapath commands.
// ----------------------------------------------------------------------------
module sstt_ctrl import sstt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t sts,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   differ;
	logic   diff_hold;

	// A differing entry must wait while a pending result cannot leave
	assign differ    = !sts.rd_eq_ns;
	assign diff_hold = differ && sts.pend_valid && !sts.out_free;

	assign in_stall = (state_q != S_IDLE);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_CHECK;
			end
			S_CHECK: begin
				if (sts.locked) state_nxt = S_ERR;
				else if (!sts.whole) state_nxt = sts.oob ? S_ERR : S_SGL;
				else state_nxt = S_FIRST;
			end
			S_ERR: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			S_SGL: begin
				if (sts.rd_eq_ns || sts.out_free) state_nxt = S_IDLE;
			end
			S_FIRST: begin
				state_nxt = sts.one_entry ? S_ALL : S_SCAN;
			end
			S_SCAN: begin
				if (!sts.rd_eq_first) state_nxt = S_DRD;
				else if (sts.rd_at_end) state_nxt = S_ALL;
			end
			S_ALL: begin
				if (sts.first_eq_ns) state_nxt = S_IDLE;
				else if (sts.out_free) state_nxt = S_FILL;
			end
			S_FILL: begin
				if (sts.ptr_at_end) state_nxt = S_IDLE;
			end
			S_DRD: begin
				state_nxt = S_DIFF;
			end
			S_DIFF: begin
				if (!diff_hold && sts.rd_at_end) state_nxt = S_FLUSH;
			end
			S_FLUSH: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		cmd.rd_sel   = ADDR_PTR;
		cmd.wr_sel   = ADDR_PTR;
		cmd.out_kind = OUT_ERR;
		case (state_q)
			S_IDLE: begin
				cmd.req_load = in_valid;
				cmd.ptr_clr  = in_valid;
			end
			S_CHECK: begin
				// start the single read or the scan at entry zero
				if (!sts.locked && !(!sts.whole && sts.oob)) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = sts.whole ? ADDR_PTR : ADDR_IDX;
					cmd.ptr_inc = sts.whole;
				end
			end
			S_ERR: begin
				cmd.out_load = sts.out_free;
				cmd.out_kind = OUT_ERR;
				cmd.out_last = 1'b1;
			end
			S_SGL: begin
				if (!sts.rd_eq_ns && sts.out_free) begin
					cmd.wr_en    = 1'b1;
					cmd.wr_sel   = ADDR_IDX;
					cmd.out_load = 1'b1;
					cmd.out_kind = OUT_SINGLE;
					cmd.out_last = 1'b1;
				end
			end
			S_FIRST: begin
				cmd.first_load = 1'b1;
				if (!sts.one_entry) begin
					cmd.rd_en   = 1'b1;
					cmd.ptr_inc = 1'b1;
				end
			end
			S_SCAN: begin
				if (!sts.rd_eq_first) begin
					cmd.ptr_clr = 1'b1;
				end else if (!sts.rd_at_end) begin
					cmd.rd_en   = 1'b1;
					cmd.ptr_inc = 1'b1;
				end
			end
			S_ALL: begin
				if (!sts.first_eq_ns && sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OUT_ALL;
					cmd.out_last = 1'b1;
					cmd.ptr_clr  = 1'b1;
				end
			end
			S_FILL: begin
				cmd.wr_en   = 1'b1;
				cmd.ptr_inc = 1'b1;
			end
			S_DRD: begin
				cmd.rd_en   = 1'b1;
				cmd.ptr_inc = 1'b1;
			end
			S_DIFF: begin
				// push the previous differing entry, hold the new one
				if (!diff_hold) begin
					if (differ) begin
						cmd.wr_en     = 1'b1;
						cmd.wr_sel    = ADDR_RD;
						cmd.pend_load = 1'b1;
						cmd.out_load  = sts.pend_valid;
						cmd.out_kind  = OUT_PEND;
					end
					if (!sts.rd_at_end) begin
						cmd.rd_en   = 1'b1;
						cmd.ptr_inc = 1'b1;
					end
				end
			end
			S_FLUSH: begin
				cmd.out_load = sts.out_free;
				cmd.out_kind = OUT_PEND;
				cmd.out_last = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### rtl/sstt_dp.sv
// ----------------------------------------------------------------------------
// sstt_dp
// Datapath of the tracker: configuration registers, state table memory with
// per-entry valid bits, request and scan registers, and the output register.
// ----------------------------------------------------------------------------
module sstt_dp import sstt_pkg::*; #(
	parameter int unsigned MAX_SUBRESOURCES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [31:0] req_state,
	input  logic        whole_resource,
	input  logic [5:0]  sub_index,
	input  cmd_t        cmd,
	output status_t     sts,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        applies_to_all,
	output logic [5:0]  out_index,
	output logic [31:0] state_before,
	output logic [31:0] state_after,
	output logic [1:0]  error_code,
	output logic        last
);

	localparam int unsigned DEPTH = (MAX_SUBRESOURCES < RESULT_LIMIT) ?
		MAX_SUBRESOURCES : RESULT_LIMIT;
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [6:0] CAP = 7'(DEPTH);

	// Configuration
	logic [6:0]       sub_count_q;
	logic             locked_q;
	logic [31:0]      fill_q;
	logic [DEPTH-1:0] valid_q;

	// Request
	logic [31:0] ns_q;
	logic        whole_q;
	logic [5:0]  idx_q;

	// Table and read port
	logic [31:0]   tbl_q [DEPTH];
	logic [31:0]   mem_q;
	logic          rdv_q;
	logic [AW-1:0] rd_idx_q;
	logic [AW-1:0] ptr_q;
	logic [31:0]   rd_data;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;

	// Scan
	logic [31:0]   first_q;
	logic          pend_valid_q;
	logic [AW-1:0] pend_idx_q;
	logic [31:0]   pend_before_q;

	// Output register
	logic        out_valid_q;
	logic        all_q;
	logic [5:0]  oidx_q;
	logic [31:0] before_q;
	logic [31:0] after_q;
	logic [1:0]  err_q;
	logic        last_q;

	logic [6:0] n_used;
	logic [6:0] n_last;
	logic       out_free;

	// Clamp the used count to 1..DEPTH
	always_comb begin
		if (sub_count_q == 7'd0) n_used = 7'd1;
		else if (sub_count_q > CAP) n_used = CAP;
		else n_used = sub_count_q;
	end
	assign n_last = n_used - 7'd1;

	// Entries never written since the last fill read as the fill value
	assign rd_data  = rdv_q ? mem_q : fill_q;
	assign out_free = !out_valid_q || !out_stall;

	// Address selection
	always_comb begin
		case (cmd.rd_sel)
			ADDR_IDX: rd_addr = idx_q[AW-1:0];
			ADDR_PTR: rd_addr = ptr_q;
			default:  rd_addr = rd_idx_q;
		endcase
		case (cmd.wr_sel)
			ADDR_IDX: wr_addr = idx_q[AW-1:0];
			ADDR_PTR: wr_addr = ptr_q;
			default:  wr_addr = rd_idx_q;
		endcase
	end

	// Configuration registers and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_count_q <= 7'd1;
			locked_q    <= 1'b0;
			fill_q      <= '0;
			valid_q     <= '0;
		end else begin
			if (cmd.wr_en) valid_q[wr_addr] <= 1'b1;
			if (cfg_valid) begin
				case (cfg_index)
					REG_SUB_COUNT: sub_count_q <= cfg_data[6:0];
					REG_LOCKED:    locked_q    <= cfg_data[0];
					REG_INIT: begin
						fill_q  <= cfg_data;
						valid_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Table memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_en) tbl_q[wr_addr] <= ns_q;
		if (cmd.rd_en) begin
			mem_q    <= tbl_q[rd_addr];
			rdv_q    <= valid_q[rd_addr];
			rd_idx_q <= rd_addr;
		end
	end

	// Request, first entry and pending result
	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			ns_q    <= req_state;
			whole_q <= whole_resource;
			idx_q   <= sub_index;
		end
		if (cmd.first_load) first_q <= rd_data;
		if (cmd.pend_load) begin
			pend_idx_q    <= rd_idx_q;
			pend_before_q <= rd_data;
		end
	end

	// Scan pointer and pending flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cmd.ptr_clr) ptr_q <= '0;
			else if (cmd.ptr_inc) ptr_q <= ptr_q + AW'(1);
			if (cmd.req_load) pend_valid_q <= 1'b0;
			else if (cmd.pend_load) pend_valid_q <= 1'b1;
		end
	end

	// Output valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			last_q <= cmd.out_last;
			case (cmd.out_kind)
				OUT_SINGLE: begin
					all_q    <= 1'b0;
					oidx_q   <= idx_q;
					before_q <= rd_data;
					after_q  <= ns_q;
					err_q    <= ERR_NONE;
				end
				OUT_ALL: begin
					all_q    <= 1'b1;
					oidx_q   <= '0;
					before_q <= first_q;
					after_q  <= ns_q;
					err_q    <= ERR_NONE;
				end
				OUT_PEND: begin
					all_q    <= 1'b0;
					oidx_q   <= 6'(pend_idx_q);
					before_q <= pend_before_q;
					after_q  <= ns_q;
					err_q    <= ERR_NONE;
				end
				default: begin
					all_q    <= 1'b0;
					oidx_q   <= '0;
					before_q <= '0;
					after_q  <= '0;
					err_q    <= locked_q ? ERR_LOCKED : ERR_RANGE;
				end
			endcase
		end
	end

	// Status to the controller
	always_comb begin
		sts.locked      = locked_q;
		sts.whole       = whole_q;
		sts.oob         = ({1'b0, idx_q} >= n_used);
		sts.one_entry   = (n_used == 7'd1);
		sts.rd_eq_ns    = (rd_data == ns_q);
		sts.rd_eq_first = (rd_data == first_q);
		sts.first_eq_ns = (first_q == ns_q);
		sts.rd_at_end   = (rd_idx_q == n_last[AW-1:0]);
		sts.ptr_at_end  = (ptr_q == n_last[AW-1:0]);
		sts.pend_valid  = pend_valid_q;
		sts.out_free    = out_free;
	end

	assign out_valid      = out_valid_q;
	assign applies_to_all = all_q;
	assign out_index      = oidx_q;
	assign state_before   = before_q;
	assign state_after    = after_q;
	assign error_code     = err_q;
	assign last           = last_q;

endmodule

### rtl/subresource_state_transition_tracker_unit.sv
// The unit takes one item at a time: in_stall stays high from the moment an item
// is accepted until its checks, scan, result outputs and any table refill are
// done, and output stalls can hold it longer. Reset clears the count to 1,
// unlocks, and reads the table as zero.
// ----------------------------------------------------------------------------
// subresource_state_transition_tracker_unit
// Tracks one 32-bit state mask per subresource and reports each state
// transition that a request causes, per entry or for the whole resource.
// ----------------------------------------------------------------------------
module subresource_state_transition_tracker_unit import sstt_pkg::*; #(
	parameter int unsigned MAX_SUBRESOURCES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] req_state,
	input  logic        whole_resource,
	input  logic [5:0]  sub_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        applies_to_all,
	output logic [5:0]  out_index,
	output logic [31:0] state_before,
	output logic [31:0] state_after,
	output logic [1:0]  error_code,
	output logic        last
);

	cmd_t    cmd;
	status_t sts;

	// Registers are to be written only while idle; the block itself does not enforce this, so always take the write
	assign cfg_ready = 1'b1;

	sstt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	sstt_dp #(
		.MAX_SUBRESOURCES (MAX_SUBRESOURCES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.req_state      (req_state),
		.whole_resource (whole_resource),
		.sub_index      (sub_index),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.applies_to_all (applies_to_all),
		.out_index      (out_index),
		.state_before   (state_before),
		.state_after    (state_after),
		.error_code     (error_code),
		.last           (last)
	);

endmodule
